### rtl/pcct_pkg.sv
// Shared types and constants for the command pulse clear tracker.
package pcct_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  typedef logic [CountW-1:0]   count_t;
  typedef logic [TotalW-1:0]   total_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EDGE_CLEAR_ENABLE = 8'd0,
    CFG_BLANK_TICKS       = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic              edge_clear_enable;
    logic [CountW-1:0] blank_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] pulse_count;
    logic              edge_seen;
    logic              latch_done;
    logic [CountW-1:0] latched_count;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] delta_pulses;
    logic [CountW-1:0] delta_raw;
    logic [TotalW-1:0] ring_total;
    logic              clear_edge;
    logic              clear_latched;
    logic              latch_rearm;
  } result_t;

endpackage

### rtl/pulse_command_clear_tracker.sv
// Top level of the command pulse clear tracker: input and result registers around the core.
// The result register is loaded from the core as the held item leaves the input register.
// Throughput: one item per cycle while out_ready holds; the tracker state updates as an item leaves the input register.
// The input register refills in the same cycle the result register is taken or is empty.
// Reset (synchronous, active low) clears both valid flags, all tracker state and the
// configuration registers; the block takes transfers from the first cycle after reset.
module pulse_command_clear_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pcct_pkg::CountW-1:0]   in_pulse_count,
  input  logic                          in_edge_seen,
  input  logic                          in_latch_done,
  input  logic [pcct_pkg::CountW-1:0]   in_latched_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [pcct_pkg::CountW-1:0] out_delta_pulses,
  output logic signed [pcct_pkg::CountW-1:0] out_delta_raw,
  output logic [pcct_pkg::TotalW-1:0]   out_ring_total,
  output logic                          out_clear_edge,
  output logic                          out_clear_latched,
  output logic                          out_latch_rearm,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcct_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pcct_pkg::CfgDataW-1:0] cfg_data
);

  // Register state: an item waits in the input register until the result register can
  // take its result; the core's state advances only on that move.
  logic              in_valid_r, in_valid_nxt;
  pcct_pkg::item_t   in_item_r;
  logic              out_valid_r, out_valid_nxt;
  pcct_pkg::result_t out_result_r;

  pcct_pkg::cfg_t    cfg;
  pcct_pkg::result_t core_result;
  pcct_pkg::item_t   in_item;
  logic              advance;
  logic              in_xfer;

  // Configuration writes are always taken; the user must write them only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  pcct_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held item moves on when the result register is empty or its result is being taken.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  assign in_item.pulse_count   = in_pulse_count;
  assign in_item.edge_seen     = in_edge_seen;
  assign in_item.latch_done    = in_latch_done;
  assign in_item.latched_count = in_latched_count;

  pcct_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (core_result)
  );

  always_comb begin
    in_valid_nxt  = in_xfer || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_result_r <= core_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_delta_pulses  = out_result_r.delta_pulses;
  assign out_delta_raw     = out_result_r.delta_raw;
  assign out_ring_total    = out_result_r.ring_total;
  assign out_clear_edge    = out_result_r.clear_edge;
  assign out_clear_latched = out_result_r.clear_latched;
  assign out_latch_rearm   = out_result_r.latch_rearm;

endmodule

### rtl/pcct_cfg_regs.sv
// Configuration register bank of the command pulse clear tracker.
module pcct_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [pcct_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [pcct_pkg::CfgDataW-1:0] wr_data,
  output pcct_pkg::cfg_t                cfg
);

  pcct_pkg::cfg_t cfg_r;
  pcct_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        pcct_pkg::CFG_EDGE_CLEAR_ENABLE: cfg_nxt.edge_clear_enable = wr_data[0];
        pcct_pkg::CFG_BLANK_TICKS:       cfg_nxt.blank_ticks = wr_data[pcct_pkg::CountW-1:0];
        default:                         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/pcct_core.sv
// Tracker state and the single-pass delta, total and clear-edge logic.
module pcct_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  pcct_pkg::item_t  item,
  input  pcct_pkg::cfg_t   cfg,
  output pcct_pkg::result_t result
);

  logic [pcct_pkg::CountW-1:0] last_count_r, last_count_nxt;
  logic [pcct_pkg::CountW-1:0] past_ref_r, past_ref_nxt;
  logic                        edge_pending_r, edge_pending_nxt;
  logic [pcct_pkg::TotalW-1:0] ring_sum_r, ring_sum_nxt;
  logic [pcct_pkg::CountW-1:0] blank_count_r, blank_count_nxt;
  logic                        mismatch_r, mismatch_nxt;

  logic [pcct_pkg::CountW-1:0] base;
  logic [pcct_pkg::CountW-1:0] d_corr;
  logic [pcct_pkg::TotalW-1:0] d_corr_ext;
  logic [pcct_pkg::CountW-1:0] d_raw;
  logic                        accepted;
  logic                        latched;
  logic                        rearm;

  always_comb begin
    base       = edge_pending_r ? past_ref_r : last_count_r;
    d_corr     = item.pulse_count - base;
    d_corr_ext = {{(pcct_pkg::TotalW-pcct_pkg::CountW){d_corr[pcct_pkg::CountW-1]}}, d_corr};
    d_raw      = item.pulse_count - last_count_r;

    accepted        = 1'b0;
    latched         = 1'b0;
    rearm           = 1'b0;
    blank_count_nxt = blank_count_r;
    mismatch_nxt    = 1'b0;

    if (blank_count_r == '0) begin
      if (item.edge_seen) begin
        accepted        = 1'b1;
        latched         = item.latch_done;
        rearm           = 1'b1;
        blank_count_nxt = cfg.blank_ticks;
      end else if (item.latch_done) begin
        // A complete latch with no edge is released on its second tick in a row.
        mismatch_nxt = !mismatch_r;
        rearm        = mismatch_r;
      end
    end else begin
      rearm           = item.latch_done;
      blank_count_nxt = blank_count_r - pcct_pkg::count_t'(1);
    end

    last_count_nxt   = item.pulse_count;
    ring_sum_nxt     = ring_sum_r + d_corr_ext;
    edge_pending_nxt = accepted && cfg.edge_clear_enable;
    past_ref_nxt     = latched ? item.latched_count : item.pulse_count;

    result.delta_pulses  = d_corr;
    result.delta_raw     = d_raw;
    result.ring_total    = ring_sum_nxt;
    result.clear_edge    = edge_pending_nxt;
    result.clear_latched = latched;
    result.latch_rearm   = rearm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r   <= '0;
      past_ref_r     <= '0;
      edge_pending_r <= 1'b0;
      ring_sum_r     <= '0;
      blank_count_r  <= '0;
      mismatch_r     <= 1'b0;
    end else if (advance) begin
      last_count_r   <= last_count_nxt;
      past_ref_r     <= past_ref_nxt;
      edge_pending_r <= edge_pending_nxt;
      ring_sum_r     <= ring_sum_nxt;
      blank_count_r  <= blank_count_nxt;
      mismatch_r     <= mismatch_nxt;
    end
  end

endmodule
